// File: design/flash_log_record_appender_defines.svh
// Assertion macros shared by the flash log record appender modules.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef FLASH_LOG_RECORD_APPENDER_DEFINES_SVH
`define FLASH_LOG_RECORD_APPENDER_DEFINES_SVH

// same-cycle implication
`define FLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/fla_pkg.sv
// Shared types, constants and the CRC-32 step function of the flash log appender.
// No dependencies.
package fla_pkg;

    localparam int SAMPLE_WORDS_DEF = 4;
    localparam int SECTOR_BYTES_DEF = 4096;
    localparam int ADDRESS_BITS_DEF = 24;

    localparam int START_W    = 24;
    localparam int END_W      = 25;
    localparam int FADDR_W    = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;
    localparam int SLOT_N     = 6;

    localparam logic [31:0] LOG_MAGIC   = 32'h464C_4F52;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [31:0] COMMIT_MARK = 32'h434F_4D4D;
    localparam logic [15:0] LOG_VERSION = 16'd1;

    localparam logic OP_ERASE = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_START = 1'b0,
        CFG_REGION_END   = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        SLOT_ERASE  = 3'd0,
        SLOT_MAGIC  = 3'd1,
        SLOT_VLEN   = 3'd2,
        SLOT_SAMPLE = 3'd3,
        SLOT_CRC    = 3'd4,
        SLOT_COMMIT = 3'd5
    } t_slot;

    typedef struct packed {
        logic [SLOT_N-1:0]  mask;
        logic [FADDR_W-1:0] base;
        logic [FADDR_W-1:0] sample_addr;
        logic [31:0]        sample;
        logic [31:0]        crc;
        logic [31:0]        records;
    } t_run;

    function automatic logic [31:0] vlen_word(input int sample_words);
        logic [15:0] rec;
        rec = 16'(16 + 4 * sample_words);
        return {rec, LOG_VERSION};
    endfunction

    // reflected CRC-32 over one little-endian word, bit by bit, LSB first
    function automatic logic [31:0] crc_word(input logic [31:0] crc_in,
                                             input logic [31:0] w);
        logic [31:0] c;
        logic        fb;
        c = crc_in;
        for (int b = 0; b < 32; b++) begin
            fb = c[0] ^ w[b];
            c  = (c >> 1) ^ (CRC_POLY & {32{fb}});
        end
        return c;
    endfunction

endpackage

// File: design/fla_in_if.sv
// Input channel of the flash log appender: one sample word per transfer.
// Depends on nothing.
interface fla_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_word;

    modport source (output valid, output sample_word, input ready);
    modport sink   (input valid, input sample_word, output ready);
endinterface

// File: design/fla_out_if.sv
// Output channel of the flash log appender: one flash command per transfer.
// Depends on nothing.
interface fla_out_if;
    logic        valid;
    logic        ready;
    logic        op_kind;
    logic [23:0] flash_address;
    logic [31:0] data_word;
    logic        last_in_run;
    logic [31:0] records_done;

    modport source (output valid, output op_kind, output flash_address, output data_word,
                    output last_in_run, output records_done, input ready);
    modport sink   (input valid, input op_kind, input flash_address, input data_word,
                    input last_in_run, input records_done, output ready);
endinterface

// File: design/flash_log_record_appender.sv
// Flash log record appender: frames sample words into CRC-32 protected flash records.
// Input channel i_in (fla_in_if) takes one sample word per transfer; output channel
// o_out (fla_out_if) gives one flash command (erase or word write) per transfer.
// Region start/end are set through i_cfg_we / i_cfg_index / i_cfg_wdata; the user
// must write them only while idle, as the block does not enforce it. Each sample
// word yields one to six commands: an erase when the placed record starts on a
// sector boundary, the magic and version/length words on the first sample of a
// record, the sample write, and the CRC and commit words on the last sample. The
// final command of each word carries last_in_run. A word passes through the input
// register and then the command run register before its first command is offered.
// Throughput: one command per cycle on o_out while o_out is ready; a word occupies
// the command sequencer until its last command transfers; a record of SAMPLE_WORDS
// words yields SAMPLE_WORDS+4 or SAMPLE_WORDS+5 commands. A new word is taken while
// the previous word's commands drain, into the input register.
// When o_out is stalled, the pending command holds and i_in backs up once the input
// register is full. Reset empties both stages, sets the write pointer to zero, the
// region to the whole 16 MiB space and the record count to zero.
// SECTOR_BYTES must be a power of two.
module flash_log_record_appender import fla_pkg::*; #(
    parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fla_in_if.sink                i_in,
    fla_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic run_valid;
    logic run_ready;
    t_run run;

    fla_framer #(
        .SAMPLE_WORDS (SAMPLE_WORDS),
        .SECTOR_BYTES (SECTOR_BYTES),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_framer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_run_ready (run_ready),
        .o_run_valid (run_valid),
        .o_run       (run)
    );

    fla_emitter #(
        .SAMPLE_WORDS (SAMPLE_WORDS)
    ) u_emitter (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_run_valid (run_valid),
        .i_run       (run),
        .o_run_ready (run_ready),
        .o_out       (o_out)
    );

endmodule

// File: design/fla_framer.sv
// Input register, region registers and record placement / CRC state of the appender.
// Depends on fla_pkg, fla_in_if and the assertion macro header.
`include "flash_log_record_appender_defines.svh"
module fla_framer import fla_pkg::*; #(
    parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    fla_in_if.sink                i_in,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_run_ready,
    output logic                  o_run_valid,
    output t_run                  o_run
);

    localparam int POS_W     = (SAMPLE_WORDS > 1) ? $clog2(SAMPLE_WORDS) : 1;
    localparam int WP_W      = (ADDRESS_BITS > START_W) ? ADDRESS_BITS : START_W;
    localparam int CW        = ((ADDRESS_BITS > END_W) ? ADDRESS_BITS : END_W) + 2;
    localparam int SEC_W     = $clog2(SECTOR_BYTES);
    localparam int REC_BYTES = 16 + 4 * SAMPLE_WORDS;
    localparam logic [CW-1:0] LREC     = CW'(REC_BYTES);
    localparam logic [CW-1:0] LSECTOR  = CW'(SECTOR_BYTES);
    localparam logic [CW-1:0] SEC_MASK = ~CW'(SECTOR_BYTES - 1);
    localparam logic [31:0]   HDR_CRC  =
        crc_word(crc_word(ALL_ONES, LOG_MAGIC), vlen_word(SAMPLE_WORDS));

    logic                  r_in_valid;
    logic [31:0]           r_in_word;
    logic [START_W-1:0]    r_region_start;
    logic [END_W-1:0]      r_region_end;
    logic [WP_W-1:0]       r_wp, n_wp;
    logic [CW-1:0]         r_base;
    logic [31:0]           r_crc, n_crc;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic [31:0]           r_records, n_records;

    logic                  step;
    logic                  rec_start;
    logic                  rec_end;
    logic                  erase;
    logic [CW-1:0]         wp_ext;
    logic [CW-1:0]         sec_end;
    logic [CW-1:0]         cand;
    logic [CW-1:0]         placed;
    logic [CW-1:0]         base_now;
    logic [CW-1:0]         next_base;
    logic [CW-1:0]         sample_addr;
    logic [31:0]           crc_new;

    assign step       = r_in_valid && i_run_ready;
    assign i_in.ready = !r_in_valid || i_run_ready;

    always_comb begin
        wp_ext      = CW'(r_wp);
        sec_end     = (wp_ext & SEC_MASK) + LSECTOR;
        cand        = (wp_ext + LREC > sec_end) ? sec_end : wp_ext;
        placed      = (cand + LREC > CW'(r_region_end)) ? CW'(r_region_start) : cand;
        erase       = (placed[SEC_W-1:0] == '0);
        rec_start   = (r_pos == '0);
        rec_end     = (r_pos == POS_W'(SAMPLE_WORDS - 1));
        base_now    = rec_start ? placed : r_base;
        crc_new     = crc_word(rec_start ? HDR_CRC : r_crc, r_in_word);
        next_base   = base_now + LREC;
        sample_addr = base_now + CW'(8) + (CW'(r_pos) << 2);

        n_wp      = r_wp;
        n_crc     = crc_new;
        n_pos     = r_pos + POS_W'(1);
        n_records = r_records;
        if (rec_end) begin
            n_crc     = ALL_ONES;
            n_pos     = '0;
            n_records = r_records + 32'd1;
            if (next_base[CW-1:ADDRESS_BITS] != '0) begin
                n_wp = WP_W'(r_region_start);
            end else begin
                n_wp = WP_W'(next_base);
            end
        end

        o_run_valid              = step;
        o_run.mask               = '0;
        o_run.mask[SLOT_ERASE]   = rec_start && erase;
        o_run.mask[SLOT_MAGIC]   = rec_start;
        o_run.mask[SLOT_VLEN]    = rec_start;
        o_run.mask[SLOT_SAMPLE]  = 1'b1;
        o_run.mask[SLOT_CRC]     = rec_end;
        o_run.mask[SLOT_COMMIT]  = rec_end;
        o_run.base               = base_now[FADDR_W-1:0];
        o_run.sample_addr        = sample_addr[FADDR_W-1:0];
        o_run.sample             = r_in_word;
        o_run.crc                = ~crc_new;
        o_run.records            = n_records;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_region_start <= '0;
            r_region_end   <= END_W'(25'h100_0000);
            r_wp           <= '0;
            r_base         <= '0;
            r_crc          <= ALL_ONES;
            r_pos          <= '0;
            r_records      <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_REGION_START: r_region_start <= i_cfg_wdata[START_W-1:0];
                    CFG_REGION_END:   r_region_end   <= i_cfg_wdata[END_W-1:0];
                endcase
            end
            if (step) begin
                r_wp      <= n_wp;
                r_base    <= base_now;
                r_crc     <= n_crc;
                r_pos     <= n_pos;
                r_records <= n_records;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_word <= i_in.sample_word;
        end
    end

    `FLA_ASSERT_IMP(a_erase_aligned, o_run_valid && o_run.mask[SLOT_ERASE],
        o_run.base[SEC_W-1:0] == '0, "erase issued at unaligned address")
    `FLA_ASSERT_IMP(a_header_pair, o_run_valid,
        o_run.mask[SLOT_MAGIC] == o_run.mask[SLOT_VLEN], "header words split")
    `FLA_ASSERT_NXT(a_pos_wrap, step && rec_end,
        r_pos == '0, "word position not cleared after record end")

endmodule

// File: design/fla_emitter.sv
// Command run register and output sequencer: emits the queued commands of one step in order.
// Depends on fla_pkg, fla_out_if and the assertion macro header.
`include "flash_log_record_appender_defines.svh"
module fla_emitter import fla_pkg::*; #(
    parameter int SAMPLE_WORDS = SAMPLE_WORDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_run_valid,
    input  t_run       i_run,
    output logic       o_run_ready,
    fla_out_if.source  o_out
);

    localparam logic [FADDR_W-1:0] TAIL_OFS = FADDR_W'(8 + 4 * SAMPLE_WORDS);
    localparam logic [31:0]        VLEN     = vlen_word(SAMPLE_WORDS);

    logic [SLOT_N-1:0]  r_mask, n_mask;
    logic [FADDR_W-1:0] r_base;
    logic [FADDR_W-1:0] r_sample_addr;
    logic [31:0]        r_sample;
    logic [31:0]        r_crc;
    logic [31:0]        r_records;

    t_slot              sel;
    logic [SLOT_N-1:0]  mask_clr;
    logic               last;
    logic               xfer;

    always_comb begin
        sel = SLOT_COMMIT;
        for (int i = SLOT_N - 1; i >= 0; i--) begin
            if (r_mask[i]) begin
                sel = t_slot'(3'(i));
            end
        end
        mask_clr    = r_mask & ~(SLOT_N'(1) << sel);
        last        = (mask_clr == '0);
        xfer        = o_out.valid && o_out.ready;
        o_run_ready = (r_mask == '0) || (xfer && last);
        n_mask      = r_mask;
        if (i_run_valid && o_run_ready) begin
            n_mask = i_run.mask;
        end else if (xfer) begin
            n_mask = mask_clr;
        end
    end

    always_comb begin
        o_out.valid        = (r_mask != '0);
        o_out.last_in_run  = last;
        o_out.records_done = r_records;
        unique case (sel)
            SLOT_ERASE: begin
                o_out.op_kind       = OP_ERASE;
                o_out.flash_address = r_base;
                o_out.data_word     = '0;
            end
            SLOT_MAGIC: begin
                o_out.op_kind       = OP_WRITE;
                o_out.flash_address = r_base;
                o_out.data_word     = LOG_MAGIC;
            end
            SLOT_VLEN: begin
                o_out.op_kind       = OP_WRITE;
                o_out.flash_address = r_base + FADDR_W'(4);
                o_out.data_word     = VLEN;
            end
            SLOT_SAMPLE: begin
                o_out.op_kind       = OP_WRITE;
                o_out.flash_address = r_sample_addr;
                o_out.data_word     = r_sample;
            end
            SLOT_CRC: begin
                o_out.op_kind       = OP_WRITE;
                o_out.flash_address = r_base + TAIL_OFS;
                o_out.data_word     = r_crc;
            end
            SLOT_COMMIT: begin
                o_out.op_kind       = OP_WRITE;
                o_out.flash_address = r_base + TAIL_OFS + FADDR_W'(4);
                o_out.data_word     = COMMIT_MARK;
            end
            default: begin
                o_out.op_kind       = OP_WRITE;
                o_out.flash_address = '0;
                o_out.data_word     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run_valid && o_run_ready) begin
            r_base        <= i_run.base;
            r_sample_addr <= i_run.sample_addr;
            r_sample      <= i_run.sample;
            r_crc         <= i_run.crc;
            r_records     <= i_run.records;
        end
    end

    `FLA_ASSERT_IMP(a_sample_queued, i_run_valid && o_run_ready,
        i_run.mask[SLOT_SAMPLE], "run loaded without sample write")
    `FLA_ASSERT_NXT(a_stall_hold, o_out.valid && !o_out.ready,
        $stable(r_mask), "pending commands changed during stall")
    `FLA_ASSERT_IMP(a_last_single, o_out.valid && o_out.last_in_run,
        $onehot(r_mask), "last flag with more commands pending")

endmodule
